### rtl/cad_pkg.sv
package cad_pkg;

  // Default limits of the decoder; the top level may override them.
  localparam int CAD_MAX_DATA_SYMBOLS  = 128;
  localparam int CAD_MAX_PREFIX_CHARS  = 31;
  localparam int CAD_MAX_PAYLOAD_BYTES = 65;

  // Queue depths (powers of two).
  localparam int CAD_IN_DEPTH  = 2;
  localparam int CAD_OUT_DEPTH = 4;

  // Length of the checksum hold-back line, in symbols.
  localparam int CAD_DLY_LEN = 8;

  // Generator terms of the 40-bit BCH polymod.
  localparam logic [39:0] CAD_GEN0 = 40'h98f2bc8e61;
  localparam logic [39:0] CAD_GEN1 = 40'h79b76d99e2;
  localparam logic [39:0] CAD_GEN2 = 40'hf33e5fb3c4;
  localparam logic [39:0] CAD_GEN3 = 40'hae2eabe2a8;
  localparam logic [39:0] CAD_GEN4 = 40'h1e4f43e470;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_CHAR     = 3'd1,
    ST_PREFIX_LONG  = 3'd2,
    ST_SHORT        = 3'd3,
    ST_CHECKSUM     = 3'd4,
    ST_LEN_MISMATCH = 3'd5,
    ST_TOO_LONG     = 3'd6
  } cad_status_e;

  // One classified character as it waits between the front and the back.
  typedef struct packed {
    logic       kind;    // 0 prefix, 1 base32 data
    logic [4:0] ch5;     // low five bits of the raw character
    logic       sym_ok;  // character is in the base32 alphabet
    logic [4:0] sym;     // its base32 value
    logic       fin;     // last character of the address
  } cad_item_t;

  typedef struct packed {
    logic [6:0]  digest_len;
    logic [3:0]  ver_type;
    cad_status_e status;
    logic [5:0]  byte_index;
    logic [7:0]  out_byte;
    logic        is_status;
    logic        end_of_result;
  } cad_result_t;

  // Results written by the back end in one cycle, first result in res0.
  typedef struct packed {
    logic [1:0]  cnt;
    cad_result_t res0;
    cad_result_t res1;
  } cad_push_t;

  function automatic logic [39:0] cad_poly_step(logic [39:0] acc, logic [4:0] v);
    logic [4:0]  top;
    logic [39:0] c;
    top = acc[39:35];
    c   = {acc[34:0], v};
    if (top[0]) c = c ^ CAD_GEN0;
    if (top[1]) c = c ^ CAD_GEN1;
    if (top[2]) c = c ^ CAD_GEN2;
    if (top[3]) c = c ^ CAD_GEN3;
    if (top[4]) c = c ^ CAD_GEN4;
    return c;
  endfunction

  // Returns {valid, symbol}; letters match in either case.
  function automatic logic [5:0] cad_sym_lookup(logic [7:0] ch);
    logic [7:0] lc;
    logic [5:0] r;
    lc = ch;
    if (ch >= 8'h41 && ch <= 8'h5a) lc = ch + 8'd32;
    case (lc)
      8'h71: r = {1'b1, 5'd0};
      8'h70: r = {1'b1, 5'd1};
      8'h7a: r = {1'b1, 5'd2};
      8'h72: r = {1'b1, 5'd3};
      8'h79: r = {1'b1, 5'd4};
      8'h39: r = {1'b1, 5'd5};
      8'h78: r = {1'b1, 5'd6};
      8'h38: r = {1'b1, 5'd7};
      8'h67: r = {1'b1, 5'd8};
      8'h66: r = {1'b1, 5'd9};
      8'h32: r = {1'b1, 5'd10};
      8'h74: r = {1'b1, 5'd11};
      8'h76: r = {1'b1, 5'd12};
      8'h64: r = {1'b1, 5'd13};
      8'h77: r = {1'b1, 5'd14};
      8'h30: r = {1'b1, 5'd15};
      8'h73: r = {1'b1, 5'd16};
      8'h33: r = {1'b1, 5'd17};
      8'h6a: r = {1'b1, 5'd18};
      8'h6e: r = {1'b1, 5'd19};
      8'h35: r = {1'b1, 5'd20};
      8'h34: r = {1'b1, 5'd21};
      8'h6b: r = {1'b1, 5'd22};
      8'h68: r = {1'b1, 5'd23};
      8'h63: r = {1'b1, 5'd24};
      8'h65: r = {1'b1, 5'd25};
      8'h36: r = {1'b1, 5'd26};
      8'h6d: r = {1'b1, 5'd27};
      8'h75: r = {1'b1, 5'd28};
      8'h61: r = {1'b1, 5'd29};
      8'h37: r = {1'b1, 5'd30};
      8'h6c: r = {1'b1, 5'd31};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] cad_digest_len(logic [2:0] len_code);
    logic [6:0] r;
    case (len_code)
      3'd0: r = 7'd20;
      3'd1: r = 7'd24;
      3'd2: r = 7'd28;
      3'd3: r = 7'd32;
      3'd4: r = 7'd40;
      3'd5: r = 7'd48;
      3'd6: r = 7'd56;
      default: r = 7'd64;
    endcase
    return r;
  endfunction

endpackage

### rtl/cad_queue.sv
module cad_queue import cad_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [1:0]                       push_cnt_i,
  input  logic [WIDTH-1:0]                 data0_i,
  input  logic [WIDTH-1:0]                 data1_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output logic [WIDTH-1:0]                 data_o,
  output logic [$clog2(DEPTH+1)-1:0]       level_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [LVL_W-1:0] level_q, level_d;

  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    level_d  = level_q + LVL_W'(push_cnt_i) - LVL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= data1_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

### rtl/cad_front.sv
module cad_front import cad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  logic [7:0] s_ch_i,
  input  logic      s_kind_i,
  input  logic      s_fin_i,
  output logic      item_valid_o,
  output cad_item_t item_o,
  input  logic      item_pop_i
);

  localparam int LVL_W = $clog2(CAD_IN_DEPTH + 1);

  cad_item_t         cls_item;
  logic [5:0]        lookup;
  logic              push;
  logic [LVL_W-1:0]  level;
  logic [$bits(cad_item_t)-1:0] q_data;

  // Classification happens on the way in, so the back end sees a ready symbol.
  always_comb begin
    lookup          = cad_sym_lookup(s_ch_i);
    cls_item.kind   = s_kind_i;
    cls_item.ch5    = s_ch_i[4:0];
    cls_item.sym_ok = lookup[5];
    cls_item.sym    = lookup[4:0];
    cls_item.fin    = s_fin_i;
  end

  assign s_ready_o = (level != LVL_W'(CAD_IN_DEPTH));
  assign push      = s_valid_i && s_ready_o;

  cad_queue #(
    .WIDTH ($bits(cad_item_t)),
    .DEPTH (CAD_IN_DEPTH)
  ) u_in_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i ({1'b0, push}),
    .data0_i    (cls_item),
    .data1_i    ('0),
    .pop_i      (item_pop_i),
    .valid_o    (item_valid_o),
    .data_o     (q_data),
    .level_o    (level)
  );

  assign item_o = q_data;

endmodule

### rtl/cad_back.sv
module cad_back import cad_pkg::*; #(
  parameter int MAX_DATA_SYMBOLS  = CAD_MAX_DATA_SYMBOLS,
  parameter int MAX_PREFIX_CHARS  = CAD_MAX_PREFIX_CHARS,
  parameter int MAX_PAYLOAD_BYTES = CAD_MAX_PAYLOAD_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  cad_item_t item_i,
  output logic      item_pop_o,
  input  logic      room_i,
  output cad_push_t push_o
);

  localparam int DC_W = $clog2(MAX_DATA_SYMBOLS + 1);
  localparam int PC_W = $clog2(MAX_PREFIX_CHARS + 1);
  localparam int BC_W = $clog2(MAX_PAYLOAD_BYTES + 1);

  logic [39:0]  poly_q, poly_d, poly_p1;
  logic [PC_W-1:0] pcnt_q, pcnt_d;
  logic [DC_W-1:0] dcnt_q, dcnt_d;
  logic [4:0]   dly_q [CAD_DLY_LEN];
  logic [4:0]   dly_d [CAD_DLY_LEN];
  logic [6:0]   bbuf_q, bbuf_d;
  logic [2:0]   bcnt_q, bcnt_d;
  logic [BC_W-1:0] bytes_q, bytes_d;
  logic [7:0]   ver_q, ver_d;
  cad_status_e  err_q, err_d;

  logic         fire;
  logic [11:0]  acc;
  logic [3:0]   bits;
  logic [7:0]   byte_val;
  logic [7:0]   bidx;
  logic         hash_emit;
  cad_result_t  hash_res, stat_res;
  cad_status_e  fstat;
  logic [6:0]   exp_len;

  assign fire       = item_valid_i && room_i;
  assign item_pop_o = fire;

  always_comb begin
    poly_d    = poly_q;
    pcnt_d    = pcnt_q;
    dcnt_d    = dcnt_q;
    dly_d     = dly_q;
    bbuf_d    = bbuf_q;
    bcnt_d    = bcnt_q;
    bytes_d   = bytes_q;
    ver_d     = ver_q;
    err_d     = err_q;
    hash_emit = 1'b0;
    hash_res  = '0;
    stat_res  = '0;
    fstat     = ST_OK;
    poly_p1   = poly_q;
    acc       = {bbuf_q, dly_q[0]};
    bits      = {1'b0, bcnt_q} + 4'd5;
    byte_val  = '0;
    bidx      = 8'(bytes_q) - 8'd1;
    exp_len   = '0;
    push_o    = '0;

    if (item_i.kind == 1'b0) begin
      if (dcnt_q != '0) begin
        if (err_d == ST_OK) err_d = ST_BAD_CHAR;
      end else if (pcnt_q >= PC_W'(MAX_PREFIX_CHARS)) begin
        if (err_d == ST_OK) err_d = ST_PREFIX_LONG;
      end else begin
        poly_d = cad_poly_step(poly_q, item_i.ch5);
        pcnt_d = pcnt_q + PC_W'(1);
      end
    end else begin
      if (dcnt_q >= DC_W'(MAX_DATA_SYMBOLS)) begin
        if (err_d == ST_OK) err_d = ST_TOO_LONG;
      end else begin
        dcnt_d = dcnt_q + DC_W'(1);
        if (!item_i.sym_ok && err_d == ST_OK) err_d = ST_BAD_CHAR;
        if (err_d == ST_OK) begin
          // The separator symbol goes in ahead of the first data symbol.
          if (dcnt_q == '0) poly_p1 = cad_poly_step(poly_q, 5'd0);
          poly_d = cad_poly_step(poly_p1, item_i.sym);
          if (dcnt_q >= DC_W'(CAD_DLY_LEN)) begin
            if (bits >= 4'd8) begin
              bits     = bits - 4'd8;
              byte_val = 8'(acc >> bits);
              bbuf_d   = 7'(acc & ((12'd1 << bits) - 12'd1));
              if (bytes_q >= BC_W'(MAX_PAYLOAD_BYTES)) begin
                err_d = ST_TOO_LONG;
              end else begin
                if (bytes_q == '0) begin
                  ver_d = byte_val;
                end else begin
                  hash_emit           = 1'b1;
                  hash_res.out_byte   = byte_val;
                  hash_res.byte_index = bidx[5:0];
                end
                bytes_d = bytes_q + BC_W'(1);
              end
            end else begin
              bbuf_d = acc[6:0];
            end
            bcnt_d = bits[2:0];
          end
          for (int i = 0; i < CAD_DLY_LEN - 1; i++) begin
            dly_d[i] = dly_q[i+1];
          end
          dly_d[CAD_DLY_LEN-1] = item_i.sym;
        end
      end
    end

    if (item_i.fin) begin
      exp_len = cad_digest_len(ver_d[2:0]);
      if (err_d == ST_PREFIX_LONG) fstat = ST_PREFIX_LONG;
      else if (dcnt_d < DC_W'(CAD_DLY_LEN)) fstat = ST_SHORT;
      else if (err_d != ST_OK) fstat = err_d;
      else if (poly_d != 40'd1) fstat = ST_CHECKSUM;
      else if (bytes_d == '0) fstat = ST_SHORT;
      else if (8'(bytes_d) != 8'(exp_len) + 8'd1) fstat = ST_LEN_MISMATCH;
      else fstat = ST_OK;
      stat_res.is_status     = 1'b1;
      stat_res.end_of_result = 1'b1;
      stat_res.status        = fstat;
      if (fstat == ST_OK) begin
        stat_res.ver_type   = ver_d[6:3];
        stat_res.digest_len = exp_len;
      end
      // Back to the reset state for the next address.
      poly_d  = 40'd1;
      pcnt_d  = '0;
      dcnt_d  = '0;
      for (int i = 0; i < CAD_DLY_LEN; i++) begin
        dly_d[i] = '0;
      end
      bbuf_d  = '0;
      bcnt_d  = '0;
      bytes_d = '0;
      ver_d   = '0;
      err_d   = ST_OK;
    end

    if (fire) begin
      if (hash_emit) begin
        push_o.res0 = hash_res;
        push_o.res1 = stat_res;
        push_o.cnt  = item_i.fin ? 2'd2 : 2'd1;
      end else begin
        push_o.res0 = stat_res;
        push_o.cnt  = item_i.fin ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= 40'd1;
      pcnt_q  <= '0;
      dcnt_q  <= '0;
      for (int i = 0; i < CAD_DLY_LEN; i++) begin
        dly_q[i] <= '0;
      end
      bbuf_q  <= '0;
      bcnt_q  <= '0;
      bytes_q <= '0;
      ver_q   <= '0;
      err_q   <= ST_OK;
    end else if (fire) begin
      poly_q  <= poly_d;
      pcnt_q  <= pcnt_d;
      dcnt_q  <= dcnt_d;
      dly_q   <= dly_d;
      bbuf_q  <= bbuf_d;
      bcnt_q  <= bcnt_d;
      bytes_q <= bytes_d;
      ver_q   <= ver_d;
      err_q   <= err_d;
    end
  end

endmodule

### rtl/cashaddr_stream_decoder_top.sv
// Dir | Bus    | tdata, low bit up                                  | tuser     | tlast
// ----+--------+----------------------------------------------------+-----------+--------------
// in  | s_axis | ch                                                 | kind      | final_char
// out | m_axis | out_byte, byte_index, status, ver_type, digest_len | is_status | end_of_result
//
// One character item is taken every cycle unless the output stalls; a character that produces
// a hash byte and the status item puts two results in the output queue, so the output drain
// sets the rate there. The polymod, the hold-back line and the unpacker are updated together
// in the back end; a character is registered in the input queue and its results in the output
// queue, which drives m_axis.
// Reset is asynchronous and active low; the block accepts items from the first cycle.
// Either side may stall: the input queue and the output queue decouple them.

module cashaddr_stream_decoder_top import cad_pkg::*; #(
  parameter int MAX_DATA_SYMBOLS  = CAD_MAX_DATA_SYMBOLS,
  parameter int MAX_PREFIX_CHARS  = CAD_MAX_PREFIX_CHARS,
  parameter int MAX_PAYLOAD_BYTES = CAD_MAX_PAYLOAD_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] kind
  input  logic        s_axis_tlast,   // final_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [13:8] byte_index, [16:14] status,
                                      // [20:17] ver_type, [27:21] digest_len, [31:28] zero
  output logic        m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast    // end_of_result
);

  localparam int OUT_LVL_W = $clog2(CAD_OUT_DEPTH + 1);

  logic                          item_valid;
  cad_item_t                     item;
  logic                          item_pop;
  cad_push_t                     push;
  logic                          room;
  logic [OUT_LVL_W-1:0]          out_level;
  logic [$bits(cad_result_t)-1:0] out_raw;
  cad_result_t                   out_res;

  // The front end classifies each character and queues it.
  cad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_ch_i       (s_axis_tdata),
    .s_kind_i     (s_axis_tuser),
    .s_fin_i      (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // The back end only fires when the output queue can take two results,
  // since a final data character may produce a hash byte and the status.
  assign room = (out_level <= OUT_LVL_W'(CAD_OUT_DEPTH - 2));

  cad_back #(
    .MAX_DATA_SYMBOLS  (MAX_DATA_SYMBOLS),
    .MAX_PREFIX_CHARS  (MAX_PREFIX_CHARS),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .room_i       (room),
    .push_o       (push)
  );

  cad_queue #(
    .WIDTH ($bits(cad_result_t)),
    .DEPTH (CAD_OUT_DEPTH)
  ) u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push.cnt),
    .data0_i    (push.res0),
    .data1_i    (push.res1),
    .pop_i      (m_axis_tvalid && m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .data_o     (out_raw),
    .level_o    (out_level)
  );

  assign out_res = out_raw;

  assign m_axis_tdata = {4'd0, out_res.digest_len, out_res.ver_type, out_res.status,
                         out_res.byte_index, out_res.out_byte};
  assign m_axis_tuser = out_res.is_status;
  assign m_axis_tlast = out_res.end_of_result;

endmodule

### rtl/cad_checker.sv
module cad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A status item always closes the address and only a status item does.
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("end_of_result and is_status disagree");

  // Hash byte items carry no status, type or length.
  a_hash_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[27:14] == 14'd0))
    else $error("hash byte item carries status fields");

  // A failing status reports no type and no length; a passing one has a length.
  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[16:14] != 3'd0 && m_axis_tdata[27:17] == 11'd0) ||
       (m_axis_tdata[16:14] == 3'd0 && m_axis_tdata[27:21] != 7'd0)))
    else $error("status item fields inconsistent");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output item changed");

  // An offered input item stays in place until the block takes it.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |=>
      (s_axis_tvalid && $stable({s_axis_tdata, s_axis_tuser, s_axis_tlast})))
    else $error("stalled input item changed");

endmodule

bind cashaddr_stream_decoder_top cad_checker u_cad_checker (.*);

### bench/cashaddr_stream_decoder_top_tb.sv
module cashaddr_stream_decoder_top_tb;
  import cad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The limits the block is built with; the predictor applies the same ones.
  localparam int MAX_DATA    = CAD_MAX_DATA_SYMBOLS;
  localparam int MAX_PREFIX  = CAD_MAX_PREFIX_CHARS;
  localparam int MAX_PAYLOAD = CAD_MAX_PAYLOAD_BYTES;

  // The run is abandoned after this many cycles, far beyond the slowest correct run.
  localparam int CYCLE_LIMIT  = 1000000;
  // The extra drain after the last owed result catches any surplus item from the block.
  localparam int DRAIN_CYCLES = 12;

  localparam bit KIND_PREFIX = 1'b0;
  localparam bit KIND_DATA   = 1'b1;

  // Generator terms of the checksum, term k applied when bit 35 + k of the state is set.
  localparam logic [4:0][39:0] BCH_GEN = {40'h1e4f43e470, 40'hae2eabe2a8, 40'hf33e5fb3c4,
                                          40'h79b76d99e2, 40'h98f2bc8e61};
  // The base32 character set; symbol value i is the i-th character from the left.
  localparam logic [255:0] BASE32_CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  // Ways in which a well-formed address is damaged before it is sent.
  typedef enum int {
    FLAW_FLIP_SYMBOL, FLAW_BAD_SYMBOL, FLAW_TRUNCATE,
    FLAW_WRONG_SIZE, FLAW_PREFIX_IN_DATA, FLAW_DROP_CHAR
  } flaw_e;

  // One decoded item as it leaves the block: a hash byte or the closing status.
  typedef struct packed {
    logic        is_status;
    logic [7:0]  out_byte;
    logic [5:0]  byte_index;
    cad_status_e status;
    logic [3:0]  ver_type;
    logic [6:0]  digest_len;
    logic        end_of_result;
  } decoded_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  cashaddr_stream_decoder_top #(
    .MAX_DATA_SYMBOLS (MAX_DATA),
    .MAX_PREFIX_CHARS (MAX_PREFIX),
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Decoder state as the predictor sees it, one address at a time.
  logic [39:0] bch_acc;
  int          prefix_seen;
  int          symbols_seen;
  logic [4:0]  holdback [8];
  int          bit_reservoir;
  int          reservoir_bits;
  int          bytes_out;
  logic [7:0]  ver_held;
  cad_status_e first_error;

  // Decoded items still owed by the block, oldest first.
  decoded_t    decoded_q [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          cycle_count = 0;

  // Idling controls: gaps before input items and stalls of the output ready.
  bit          send_gaps = 1'b0;
  bit          out_stalls = 1'b0;
  int          stall_left = 0;

  // The address being assembled for sending: one character and its kind per entry.
  logic [7:0]  addr_ch [$];
  bit          addr_kind [$];

  function automatic logic [39:0] bch_advance(logic [39:0] acc, logic [4:0] v);
    logic [39:0] nxt;
    nxt = {acc[34:0], v};
    for (int k = 0; k < 5; k++)
      if (acc[35 + k]) nxt ^= BCH_GEN[k];
    return nxt;
  endfunction

  function automatic logic [7:0] charset_at(int i);
    return BASE32_CHARSET[8 * (31 - i) +: 8];
  endfunction

  // Symbol value of a character, or -1 when it lies outside the alphabet.
  function automatic int base32_value(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;  // fold upper-case letters
    for (int i = 0; i < 32; i++)
      if (charset_at(i) == lc) return i;
    return -1;
  endfunction

  // Hash length coded by the three size bits of the version byte.
  function automatic int size_bytes(logic [2:0] s);
    return (s < 3'd4) ? 20 + 4 * int'(s) : 40 + 8 * (int'(s) - 4);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic void clear_decoder();
    bch_acc        = 40'd1;
    prefix_seen    = 0;
    symbols_seen   = 0;
    foreach (holdback[k]) holdback[k] = 5'd0;
    bit_reservoir  = 0;
    reservoir_bits = 0;
    bytes_out      = 0;
    ver_held       = 8'h00;
    first_error    = ST_OK;
  endfunction

  function automatic void note_error(cad_status_e e);
    if (first_error == ST_OK) first_error = e;
  endfunction

  // A symbol leaving the hold-back line is unpacked five bits at a time into bytes.
  function automatic void unpack_symbol(logic [4:0] s);
    int         acc;
    int         nb;
    logic [7:0] b;
    decoded_t   r;
    acc = (bit_reservoir << 5) | int'(s);
    nb  = reservoir_bits + 5;
    if (nb >= 8) begin
      nb -= 8;
      b = 8'(acc >> nb);
      bit_reservoir = acc & ((1 << nb) - 1);
      if (bytes_out >= MAX_PAYLOAD) begin
        note_error(ST_TOO_LONG);
      end else begin
        if (bytes_out == 0) begin
          ver_held = b;
        end else begin
          r = '0;
          r.out_byte   = b;
          r.byte_index = 6'(bytes_out - 1);
          decoded_q.push_back(r);
        end
        bytes_out++;
      end
    end else begin
      bit_reservoir = acc & 7'h7f;
    end
    reservoir_bits = nb & 7;
  endfunction

  // Works out what one accepted character makes the block emit.
  function automatic void decode_char(bit kind, logic [7:0] ch, bit fin);
    int       sym;
    bit       first;
    bit       full;
    int       want_len;
    decoded_t r;
    if (kind == KIND_PREFIX) begin
      if (symbols_seen != 0) begin
        note_error(ST_BAD_CHAR);
      end else if (prefix_seen >= MAX_PREFIX) begin
        note_error(ST_PREFIX_LONG);
      end else begin
        bch_acc = bch_advance(bch_acc, ch[4:0]);
        prefix_seen++;
      end
    end else begin
      sym = base32_value(ch);
      if (symbols_seen >= MAX_DATA) begin
        note_error(ST_TOO_LONG);
      end else begin
        first = (symbols_seen == 0);
        full  = (symbols_seen >= 8);
        symbols_seen++;
        if (sym < 0) note_error(ST_BAD_CHAR);
        if (first_error == ST_OK) begin
          // The separator symbol goes in just before the first data symbol.
          if (first) bch_acc = bch_advance(bch_acc, 5'd0);
          bch_acc = bch_advance(bch_acc, 5'(sym));
          if (full) unpack_symbol(holdback[0]);
          for (int k = 0; k < 7; k++) holdback[k] = holdback[k + 1];
          holdback[7] = 5'(sym);
        end
      end
    end

    if (fin) begin
      want_len = size_bytes(ver_held[2:0]);
      r = '0;
      r.is_status     = 1'b1;
      r.end_of_result = 1'b1;
      if (first_error == ST_PREFIX_LONG) r.status = ST_PREFIX_LONG;
      else if (symbols_seen < 8)         r.status = ST_SHORT;
      else if (first_error != ST_OK)     r.status = first_error;
      else if (bch_acc != 40'd1)         r.status = ST_CHECKSUM;
      else if (bytes_out < 1)            r.status = ST_SHORT;
      else if (bytes_out != 1 + want_len) r.status = ST_LEN_MISMATCH;
      else                               r.status = ST_OK;
      if (r.status == ST_OK) begin
        r.ver_type   = ver_held[6:3];
        r.digest_len = 7'(want_len);
      end
      decoded_q.push_back(r);
      clear_decoder();
    end
  endfunction

  // Offers one character, optionally after a gap, and predicts once it is taken.
  task automatic send_char(bit kind, logic [7:0] ch, bit fin);
    int gap;
    gap = (send_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_char(kind, ch, fin);
    items_sent++;
  endtask

  task automatic send_address();
    foreach (addr_ch[i]) send_char(addr_kind[i], addr_ch[i], i == addr_ch.size() - 1);
  endtask

  function automatic logic [7:0] random_data_char();
    logic [7:0] c;
    c = charset_at($urandom_range(0, 31));
    if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 3) == 0) c -= 8'd32;
    return c;
  endfunction

  // Builds a well-formed address: prefix, version byte and hash bytes packed into
  // five-bit symbols, then the eight checksum symbols that bring the state back to one.
  task automatic make_address(int pfx_len, logic [7:0] version, int n_hash);
    logic [4:0]  syms [$];
    logic [39:0] acc;
    int          pending;
    int          npend;
    logic [7:0]  b;
    logic [7:0]  c;
    addr_ch.delete();
    addr_kind.delete();
    acc = 40'd1;
    for (int i = 0; i < pfx_len; i++) begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(8'h61, 8'h7a));
      acc = bch_advance(acc, c[4:0]);
      addr_ch.push_back(c);
      addr_kind.push_back(KIND_PREFIX);
    end
    acc = bch_advance(acc, 5'd0);
    pending = 0;
    npend   = 0;
    for (int i = 0; i <= n_hash; i++) begin
      b = (i == 0) ? version : 8'($urandom);
      pending = (pending << 8) | int'(b);
      npend += 8;
      while (npend >= 5) begin
        npend -= 5;
        syms.push_back(5'(pending >> npend));
        pending &= (1 << npend) - 1;
      end
    end
    if (npend > 0) syms.push_back(5'(pending << (5 - npend)));
    foreach (syms[i]) acc = bch_advance(acc, syms[i]);
    repeat (8) acc = bch_advance(acc, 5'd0);
    acc ^= 40'd1;
    for (int i = 7; i >= 0; i--) syms.push_back(acc[5 * i +: 5]);
    foreach (syms[i]) begin
      c = charset_at(syms[i]);
      if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 3) == 0) c -= 8'd32;
      addr_ch.push_back(c);
      addr_kind.push_back(KIND_DATA);
    end
  endtask

  // Short hand-picked addresses: the end of an address on a prefix character,
  // a prefix character after data, characters outside the alphabet (0x00 and 0xFF
  // among them), mixed case, and eight data symbols that cannot carry a checksum.
  task automatic test_directed_edges();
    string s;
    send_gaps  = 1'b0;
    out_stalls = 1'b0;
    send_char(KIND_PREFIX, 8'h00, 1'b1);

    send_char(KIND_PREFIX, 8'hff, 1'b0);
    s = "qPzRy9X8";
    for (int i = 0; i < s.len(); i++) send_char(KIND_DATA, s[i], 1'b0);
    send_char(KIND_PREFIX, "a", 1'b0);
    send_char(KIND_DATA, "L", 1'b1);

    send_char(KIND_DATA, "m", 1'b0);
    send_char(KIND_DATA, "U", 1'b0);
    send_char(KIND_DATA, 8'hff, 1'b0);
    send_char(KIND_DATA, "a", 1'b0);
    send_char(KIND_DATA, "7", 1'b0);
    send_char(KIND_DATA, "l", 1'b0);
    send_char(KIND_DATA, 8'h00, 1'b0);
    send_char(KIND_DATA, "E", 1'b1);

    for (int i = 0; i < 8; i++) send_char(KIND_DATA, "q", i == 7);
  endtask

  // Correct addresses of every size code and type, with random prefixes, so the
  // unpacker and the final checks all run to the end and report success.
  task automatic test_valid_addresses(int until_items);
    logic [7:0] version;
    int         pfx_len;
    while (items_sent < until_items) begin
      send_gaps  = ($urandom_range(0, 3) != 0);
      out_stalls = ($urandom_range(0, 3) != 0);
      version = 8'($urandom);
      pfx_len = ($urandom_range(0, 9) == 0) ? MAX_PREFIX : $urandom_range(0, 12);
      make_address(pfx_len, version, size_bytes(version[2:0]));
      send_address();
    end
  endtask

  // Well-formed addresses with one flaw each, so the failing statuses short of the limits
  // are reached, in most cases after tentative hash bytes have already gone out.
  task automatic test_corrupted_addresses(int until_items);
    logic [7:0] version;
    logic [7:0] c;
    int         pfx_len;
    int         n_hash;
    int         idx;
    flaw_e      flaw;
    while (items_sent < until_items) begin
      send_gaps  = ($urandom_range(0, 2) != 0);
      out_stalls = ($urandom_range(0, 2) != 0);
      flaw    = flaw_e'($urandom_range(0, 5));
      version = 8'($urandom);
      pfx_len = $urandom_range(0, 10);
      n_hash  = size_bytes(version[2:0]);
      if (flaw == FLAW_WRONG_SIZE) n_hash = $urandom_range(1, 64);
      make_address(pfx_len, version, n_hash);
      idx = $urandom_range(pfx_len, addr_ch.size() - 1);
      case (flaw)
        FLAW_FLIP_SYMBOL: begin
          addr_ch[idx] = charset_at((base32_value(addr_ch[idx]) + $urandom_range(1, 31)) % 32);
        end
        FLAW_BAD_SYMBOL: begin
          do c = 8'($urandom_range(0, 255)); while (base32_value(c) >= 0);
          addr_ch[idx] = c;
        end
        FLAW_TRUNCATE: begin
          while (addr_ch.size() > idx + 1) begin
            void'(addr_ch.pop_back());
            void'(addr_kind.pop_back());
          end
        end
        FLAW_PREFIX_IN_DATA: begin
          addr_kind[idx] = KIND_PREFIX;
        end
        FLAW_DROP_CHAR: begin
          addr_ch.delete(idx);
          addr_kind.delete(idx);
        end
        default: begin
        end
      endcase
      send_address();
    end
  endtask

  // Addresses past each limit: a prefix one to six characters too long, a payload of more
  // bytes than allowed, and more data symbols than the block holds.
  task automatic test_overlong(int rounds);
    logic [7:0] version;
    for (int r = 0; r < rounds; r++) begin
      send_gaps  = (r % 2 == 1);
      out_stalls = (r % 2 == 0);
      version = 8'($urandom);
      make_address(MAX_PREFIX + $urandom_range(1, 6), version, size_bytes(version[2:0]));
      send_address();
      make_address($urandom_range(0, 4), version, MAX_PAYLOAD + $urandom_range(0, 5));
      send_address();
      make_address($urandom_range(0, 4), version, 64);
      for (int i = 0; i < MAX_DATA - 112 + $urandom_range(1, 12); i++) begin
        addr_ch.push_back(random_data_char());
        addr_kind.push_back(KIND_DATA);
      end
      send_address();
    end
  endtask

  // Raw characters of either kind with scattered address ends.
  task automatic test_noise(int count);
    logic [7:0] c;
    send_gaps  = 1'b1;
    out_stalls = 1'b1;
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : random_data_char();
      send_char(bit'($urandom_range(0, 1)), c, $urandom_range(0, 9) == 0);
    end
    send_char(KIND_DATA, random_data_char(), 1'b1);
  endtask

  // Output ready: stalls of random length, started now and then when enabled.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (out_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Every item taken from the output is checked against the oldest prediction.
  always @(posedge clk_i) begin
    decoded_t want;
    decoded_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.is_status     = m_axis_tuser;
      got.out_byte      = m_axis_tdata[7:0];
      got.byte_index    = m_axis_tdata[13:8];
      got.status        = cad_status_e'(m_axis_tdata[16:14]);
      got.ver_type      = m_axis_tdata[20:17];
      got.digest_len    = m_axis_tdata[27:21];
      got.end_of_result = m_axis_tlast;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item, actual tdata %h tuser %b tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        compare_field("is_status", want.is_status, got.is_status);
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("byte_index", want.byte_index, got.byte_index);
        compare_field("status", want.status, got.status);
        compare_field("ver_type", want.ver_type, got.ver_type);
        compare_field("digest_len", want.digest_len, got.digest_len);
        compare_field("end_of_result", want.end_of_result, got.end_of_result);
      end
    end
  end

  // A hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_decoder();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_valid_addresses(600);
    test_corrupted_addresses(850);
    test_overlong(1);
    test_noise(100);

    // Let every owed result drain with no new output stalls, then a little more
    // so that any surplus item from the block is caught.
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    out_stalls = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
